### rtl/core/psmt_pkg.sv
// ----------------------------------------------------------------------------
// psmt_pkg
// Shared types, constants and helpers of the polygon separating-axis core.
// ----------------------------------------------------------------------------
package psmt_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 16;

	// push vector format: signed Q16.16
	localparam int PUSH_W    = 32;
	localparam int FRAC_BITS = 16;

	localparam logic [PUSH_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [PUSH_W-1:0] SAT_NEG = 32'h8000_0000;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_DROP  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

### rtl/core/psmt_vert_if.sv
// ----------------------------------------------------------------------------
// psmt_vert_if
// Vertex channel: one polygon vertex per transfer.
// ----------------------------------------------------------------------------
interface psmt_vert_if #(
	parameter int COORD_WIDTH = psmt_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [COORD_WIDTH-1:0] vert_x;
	logic signed [COORD_WIDTH-1:0] vert_y;
	logic                          last_vertex;

	modport source (output valid, output mode, output vert_x, output vert_y,
		output last_vertex, input ready);
	modport sink (input valid, input mode, input vert_x, input vert_y,
		input last_vertex, output ready);
endinterface

### rtl/core/psmt_res_if.sv
// ----------------------------------------------------------------------------
// psmt_res_if
// Result channel: hit flag, push vector and status of one test.
// ----------------------------------------------------------------------------
interface psmt_res_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [psmt_pkg::PUSH_W-1:0] push_x;
	logic signed [psmt_pkg::PUSH_W-1:0] push_y;
	logic [1:0]                        status;

	modport source (output valid, output hit, output push_x, output push_y,
		output status, input ready);
	modport sink (input valid, input hit, input push_x, input push_y,
		input status, output ready);
endinterface

### rtl/core/polygon_sat_min_translation_core.sv
// ----------------------------------------------------------------------------
// polygon_sat_min_translation_core
// Separating-axis test of two convex polygons with minimum push vector.
// ----------------------------------------------------------------------------
// usage:
//   vert   : one vertex per transfer, mode 0 to polygon A, 1 to polygon B.
//            A vertex beyond MAX_VERTICES per polygon is dropped and flagged.
//            last_vertex stores the vertex and then starts the test.
//   result : one transfer per test: hit, push_x/push_y (Q16.16), status.
// sequencing:
//   a vertex without last_vertex is stored and the core stays ready. The test
//   runs on a small sequencer around one registered projection multiplier, a
//   shift-add multiplier and a restoring divider. Each non-zero edge runs a
//   projection of both polygons and, if they overlap on it, push arithmetic;
//   a final orientation step follows. vert.ready is low for the whole test.
// reset: vertex counts, drop flag and result valid clear; stored vertices
//   are not cleared and only entries below the counts are read.
// stall: a finished result waits in the output register; new vertices are
//   still taken meanwhile, and the next test holds before its own result
//   until the previous one has been taken.
// ----------------------------------------------------------------------------
module polygon_sat_min_translation_core #(
	parameter int MAX_VERTICES = psmt_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = psmt_pkg::COORD_WIDTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	psmt_vert_if.sink   vert,
	psmt_res_if.source  result
);
	localparam int CW   = COORD_WIDTH;
	localparam int AW   = CW + 1;
	localparam int PW   = 2 * AW;
	localparam int DW   = PW + 1;
	localparam int DPW  = DW + 1;
	localparam int LW   = PW;
	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int SW   = CW + CNTW;
	localparam int UW   = SW + CNTW + 1;
	localparam int QW   = psmt_pkg::PUSH_W;
	localparam int MB   = QW;
	localparam int MA   = psmt_pkg::max_int(psmt_pkg::max_int(DPW, UW), QW);
	localparam int PRW  = MA + MB;
	localparam int NW   = PRW + psmt_pkg::FRAC_BITS;
	localparam int D2W  = 2 * QW;
	localparam int MEMD = 2 ** (IW + 1);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_START   = 5'd1;
	localparam logic [4:0] ST_RDI     = 5'd2;
	localparam logic [4:0] ST_RDJ     = 5'd3;
	localparam logic [4:0] ST_EDGE    = 5'd4;
	localparam logic [4:0] ST_LEN0    = 5'd5;
	localparam logic [4:0] ST_LEN1    = 5'd6;
	localparam logic [4:0] ST_LEN2    = 5'd7;
	localparam logic [4:0] ST_PRD     = 5'd8;
	localparam logic [4:0] ST_PMX     = 5'd9;
	localparam logic [4:0] ST_PMY     = 5'd10;
	localparam logic [4:0] ST_PACC    = 5'd11;
	localparam logic [4:0] ST_SEP     = 5'd12;
	localparam logic [4:0] ST_PMUL    = 5'd13;
	localparam logic [4:0] ST_PMWAIT  = 5'd14;
	localparam logic [4:0] ST_PDIV    = 5'd15;
	localparam logic [4:0] ST_PDWAIT  = 5'd16;
	localparam logic [4:0] ST_SQ      = 5'd17;
	localparam logic [4:0] ST_SQWAIT  = 5'd18;
	localparam logic [4:0] ST_BEST    = 5'd19;
	localparam logic [4:0] ST_NEXT    = 5'd20;
	localparam logic [4:0] ST_ORIENT  = 5'd21;
	localparam logic [4:0] ST_DOT     = 5'd22;
	localparam logic [4:0] ST_DOTWAIT = 5'd23;
	localparam logic [4:0] ST_DONE    = 5'd24;

	function automatic logic [QW-1:0] neg_sat(input logic [QW-1:0] v);
		return (v == psmt_pkg::SAT_NEG) ? psmt_pkg::SAT_POS : -v;
	endfunction

	// control state
	logic [4:0]             state_q;
	logic [CNTW-1:0]        cnt_a_q, cnt_b_q;
	logic                   ovf_q;
	logic signed [SW-1:0]   sum_ax_q, sum_ay_q, sum_bx_q, sum_by_q;
	logic                   poly_q, pp_q, comp_q, have_q;
	logic [IW-1:0]          idx_q, pk_q;
	logic                   out_valid_q;

	// datapath
	logic [2*CW-1:0]        mem [MEMD];
	logic [2*CW-1:0]        rd_q;
	logic signed [CW-1:0]   vi_x_q, vi_y_q;
	logic signed [AW-1:0]   ax_q, ay_q;
	logic [LW-1:0]          len2_q;
	logic signed [PW-1:0]   prod_q, dot_q;
	logic signed [DW-1:0]   mina_q, maxa_q, minb_q, maxb_q;
	logic [DPW-1:0]         depth_q;
	logic [QW-1:0]          px_q, py_q, bx_q, by_q;
	logic [PRW-1:0]         acc_q;
	logic [D2W-1:0]         d2_q, best_q;
	logic signed [UW-1:0]   ux_q, uy_q;
	logic                   r_hit_q;
	logic [QW-1:0]          r_px_q, r_py_q;
	logic [1:0]             r_status_q;
	logic                   o_hit_q;
	logic [QW-1:0]          o_px_q, o_py_q;
	logic [1:0]             o_status_q;

	// combinational
	logic                   accept, store_ok, out_free, empty;
	logic [CNTW-1:0]        cnt_vert, cnt_poly, cnt_pp, cnt_poly_m1, cnt_pp_m1;
	logic [IW-1:0]          last_idx, last_pk, jdx;
	logic [IW:0]            rd_addr;
	logic                   rd_en;
	logic signed [CW-1:0]   rd_x, rd_y;
	logic signed [AW-1:0]   ex_c, ey_c, mul_a, mul_b;
	logic signed [DW-1:0]   dot_c;
	logic                   sep_c;
	logic signed [DPW-1:0]  d0_c, d1_c;
	logic signed [CNTW:0]   ca_s, cb_s;
	logic signed [UW-1:0]   pax_c, pay_c, pbx_c, pby_c, ux_c, uy_c;
	logic [AW-1:0]          ax_mag, ay_mag;
	logic [QW-1:0]          px_mag, py_mag, bx_mag, by_mag;
	logic [UW-1:0]          ux_mag, uy_mag;
	logic                   mul_start, div_start;
	logic [MA-1:0]          sm_a;
	logic [MB-1:0]          sm_b;
	logic [PRW-1:0]         mul_prod;
	psmt_pkg::unit_stat_t   mul_stat, div_stat;
	logic [QW-1:0]          div_quo;
	logic                   div_sat;
	logic                   push_neg;
	logic [QW-1:0]          lim_c, qc_c, push_c;
	logic [D2W-1:0]         d2_c;
	logic signed [PRW+1:0]  t1_c, t2_c, dsum_c;
	logic                   flip_c;
	logic [1:0]             st_ok;

	assign accept   = vert.valid && vert.ready;
	assign cnt_vert = vert.mode ? cnt_b_q : cnt_a_q;
	assign store_ok = cnt_vert < CNTW'(MAX_VERTICES);
	assign out_free = !out_valid_q || result.ready;
	assign empty    = (cnt_a_q == '0) || (cnt_b_q == '0);
	assign st_ok    = ovf_q ? psmt_pkg::STATUS_DROP : psmt_pkg::STATUS_OK;

	assign cnt_poly    = poly_q ? cnt_b_q : cnt_a_q;
	assign cnt_pp      = pp_q ? cnt_b_q : cnt_a_q;
	assign cnt_poly_m1 = cnt_poly - 1'b1;
	assign cnt_pp_m1   = cnt_pp - 1'b1;
	assign last_idx    = cnt_poly_m1[IW-1:0];
	assign last_pk     = cnt_pp_m1[IW-1:0];
	// previous vertex, wrapping to the last one
	assign jdx         = (idx_q == '0) ? last_idx : idx_q - 1'b1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {poly_q, idx_q};
		unique case (state_q)
			ST_RDI: begin
				rd_en   = 1'b1;
				rd_addr = {poly_q, idx_q};
			end
			ST_RDJ: begin
				rd_en   = 1'b1;
				rd_addr = {poly_q, jdx};
			end
			ST_PRD: begin
				rd_en   = 1'b1;
				rd_addr = {pp_q, pk_q};
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = {poly_q, idx_q};
			end
		endcase
	end

	assign rd_x = $signed(rd_q[2*CW-1:CW]);
	assign rd_y = $signed(rd_q[CW-1:0]);

	assign ex_c = AW'(vi_x_q) - AW'(rd_x);
	assign ey_c = AW'(vi_y_q) - AW'(rd_y);

	// projection / squared length multiplier operands
	always_comb begin
		unique case (state_q)
			ST_LEN1: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
			ST_PMX: begin
				mul_a = ax_q;
				mul_b = AW'(rd_x);
			end
			ST_PMY: begin
				mul_a = ay_q;
				mul_b = AW'(rd_y);
			end
			default: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
		endcase
	end

	assign dot_c = DW'(dot_q) + DW'(prod_q);
	assign sep_c = (mina_q > maxb_q) || (minb_q > maxa_q);
	assign d0_c  = DPW'(maxa_q) - DPW'(minb_q);
	assign d1_c  = DPW'(maxb_q) - DPW'(mina_q);

	// centroid difference scaled by both counts
	assign ca_s  = $signed({1'b0, cnt_a_q});
	assign cb_s  = $signed({1'b0, cnt_b_q});
	assign pax_c = sum_ax_q * cb_s;
	assign pay_c = sum_ay_q * cb_s;
	assign pbx_c = sum_bx_q * ca_s;
	assign pby_c = sum_by_q * ca_s;
	assign ux_c  = pax_c - pbx_c;
	assign uy_c  = pay_c - pby_c;

	assign ax_mag = ax_q[AW-1] ? -ax_q : ax_q;
	assign ay_mag = ay_q[AW-1] ? -ay_q : ay_q;
	assign px_mag = px_q[QW-1] ? -px_q : px_q;
	assign py_mag = py_q[QW-1] ? -py_q : py_q;
	assign bx_mag = bx_q[QW-1] ? -bx_q : bx_q;
	assign by_mag = by_q[QW-1] ? -by_q : by_q;
	assign ux_mag = ux_q[UW-1] ? -ux_q : ux_q;
	assign uy_mag = uy_q[UW-1] ? -uy_q : uy_q;

	// shared serial multiplier operands
	always_comb begin
		mul_start = 1'b0;
		sm_a      = MA'(depth_q);
		sm_b      = MB'(ax_mag);
		unique case (state_q)
			ST_PMUL: begin
				mul_start = 1'b1;
				sm_a      = MA'(depth_q);
				sm_b      = comp_q ? MB'(ay_mag) : MB'(ax_mag);
			end
			ST_SQ: begin
				mul_start = 1'b1;
				sm_a      = comp_q ? MA'(py_mag) : MA'(px_mag);
				sm_b      = comp_q ? py_mag : px_mag;
			end
			ST_DOT: begin
				mul_start = 1'b1;
				sm_a      = comp_q ? MA'(uy_mag) : MA'(ux_mag);
				sm_b      = comp_q ? by_mag : bx_mag;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == ST_PDIV);

	psmt_mul #(
		.MA (MA),
		.MB (MB)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sm_a),
		.b      (sm_b),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	psmt_div #(
		.NW (NW),
		.LW (LW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({mul_prod, {psmt_pkg::FRAC_BITS{1'b0}}}),
		.den    (len2_q),
		.quo    (div_quo),
		.sat    (div_sat),
		.stat   (div_stat)
	);

	// push component from quotient: clamp, then apply the axis sign
	assign push_neg = comp_q ? ay_q[AW-1] : ax_q[AW-1];
	assign lim_c    = push_neg ? psmt_pkg::SAT_NEG : psmt_pkg::SAT_POS;
	assign qc_c     = (div_sat || (div_quo > lim_c)) ? lim_c : div_quo;
	assign push_c   = push_neg ? -qc_c : qc_c;

	assign d2_c = acc_q[D2W-1:0] + mul_prod[D2W-1:0];

	// exact sign of ux*bx + uy*by
	always_comb begin
		t1_c = $signed({2'b00, acc_q});
		t2_c = $signed({2'b00, mul_prod});
		if (ux_q[UW-1] ^ bx_q[QW-1]) begin
			t1_c = -t1_c;
		end
		if (uy_q[UW-1] ^ by_q[QW-1]) begin
			t2_c = -t2_c;
		end
		dsum_c = t1_c + t2_c;
		flip_c = dsum_c[PRW+1];
	end

	assign vert.ready    = (state_q == ST_IDLE);
	assign result.valid  = out_valid_q;
	assign result.hit    = o_hit_q;
	assign result.push_x = o_px_q;
	assign result.push_y = o_py_q;
	assign result.status = o_status_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			sum_ax_q    <= '0;
			sum_ay_q    <= '0;
			sum_bx_q    <= '0;
			sum_by_q    <= '0;
			poly_q      <= 1'b0;
			pp_q        <= 1'b0;
			comp_q      <= 1'b0;
			have_q      <= 1'b0;
			idx_q       <= '0;
			pk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							if (vert.mode) begin
								cnt_b_q  <= cnt_b_q + 1'b1;
								sum_bx_q <= sum_bx_q + SW'(vert.vert_x);
								sum_by_q <= sum_by_q + SW'(vert.vert_y);
							end else begin
								cnt_a_q  <= cnt_a_q + 1'b1;
								sum_ax_q <= sum_ax_q + SW'(vert.vert_x);
								sum_ay_q <= sum_ay_q + SW'(vert.vert_y);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (vert.last_vertex) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					poly_q <= 1'b0;
					idx_q  <= '0;
					have_q <= 1'b0;
					state_q <= empty ? ST_DONE : ST_RDI;
				end
				ST_RDI: state_q <= ST_RDJ;
				ST_RDJ: state_q <= ST_EDGE;
				ST_EDGE: begin
					state_q <= ((ex_c == '0) && (ey_c == '0)) ? ST_NEXT : ST_LEN0;
				end
				ST_LEN0: state_q <= ST_LEN1;
				ST_LEN1: state_q <= ST_LEN2;
				ST_LEN2: begin
					pp_q    <= 1'b0;
					pk_q    <= '0;
					state_q <= ST_PRD;
				end
				ST_PRD: state_q <= ST_PMX;
				ST_PMX: state_q <= ST_PMY;
				ST_PMY: state_q <= ST_PACC;
				ST_PACC: begin
					if (pk_q == last_pk) begin
						pk_q <= '0;
						if (!pp_q) begin
							pp_q    <= 1'b1;
							state_q <= ST_PRD;
						end else begin
							state_q <= ST_SEP;
						end
					end else begin
						pk_q    <= pk_q + 1'b1;
						state_q <= ST_PRD;
					end
				end
				ST_SEP: begin
					comp_q  <= 1'b0;
					state_q <= sep_c ? ST_DONE : ST_PMUL;
				end
				ST_PMUL: state_q <= ST_PMWAIT;
				ST_PMWAIT: begin
					if (mul_stat.done) begin
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: state_q <= ST_PDWAIT;
				ST_PDWAIT: begin
					if (div_stat.done) begin
						comp_q  <= !comp_q;
						state_q <= comp_q ? ST_SQ : ST_PMUL;
					end
				end
				ST_SQ: state_q <= ST_SQWAIT;
				ST_SQWAIT: begin
					if (mul_stat.done) begin
						comp_q  <= !comp_q;
						state_q <= comp_q ? ST_BEST : ST_SQ;
					end
				end
				ST_BEST: begin
					have_q  <= 1'b1;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (idx_q == last_idx) begin
						idx_q <= '0;
						if (!poly_q) begin
							poly_q  <= 1'b1;
							state_q <= ST_RDI;
						end else begin
							state_q <= ST_ORIENT;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RDI;
					end
				end
				ST_ORIENT: begin
					comp_q  <= 1'b0;
					state_q <= have_q ? ST_DOT : ST_DONE;
				end
				ST_DOT: state_q <= ST_DOTWAIT;
				ST_DOTWAIT: begin
					if (mul_stat.done) begin
						comp_q  <= !comp_q;
						state_q <= comp_q ? ST_DONE : ST_DOT;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_q       <= 1'b0;
						sum_ax_q    <= '0;
						sum_ay_q    <= '0;
						sum_bx_q    <= '0;
						sum_by_q    <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (accept && store_ok) begin
			mem[{vert.mode, cnt_vert[IW-1:0]}] <= {vert.vert_x, vert.vert_y};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_START: begin
				ux_q <= ux_c;
				uy_q <= uy_c;
				if (empty) begin
					r_hit_q    <= 1'b0;
					r_px_q     <= '0;
					r_py_q     <= '0;
					r_status_q <= psmt_pkg::STATUS_EMPTY;
				end
			end
			ST_RDJ: begin
				vi_x_q <= rd_x;
				vi_y_q <= rd_y;
			end
			ST_EDGE: begin
				ax_q <= -ey_c;
				ay_q <= ex_c;
			end
			ST_LEN1: len2_q <= $unsigned(prod_q);
			ST_LEN2: len2_q <= len2_q + $unsigned(prod_q);
			ST_PMY:  dot_q  <= prod_q;
			ST_PACC: begin
				if (!pp_q) begin
					if (pk_q == '0 || dot_c < mina_q) mina_q <= dot_c;
					if (pk_q == '0 || dot_c > maxa_q) maxa_q <= dot_c;
				end else begin
					if (pk_q == '0 || dot_c < minb_q) minb_q <= dot_c;
					if (pk_q == '0 || dot_c > maxb_q) maxb_q <= dot_c;
				end
			end
			ST_SEP: begin
				if (sep_c) begin
					r_hit_q    <= 1'b0;
					r_px_q     <= '0;
					r_py_q     <= '0;
					r_status_q <= st_ok;
				end else begin
					depth_q <= (d0_c < d1_c) ? $unsigned(d0_c) : $unsigned(d1_c);
				end
			end
			ST_PDWAIT: begin
				if (div_stat.done) begin
					if (comp_q) py_q <= push_c;
					else px_q <= push_c;
				end
			end
			ST_SQWAIT: begin
				if (mul_stat.done) begin
					if (comp_q) d2_q <= d2_c;
					else acc_q <= mul_prod;
				end
			end
			ST_BEST: begin
				if (!have_q || d2_q < best_q) begin
					best_q <= d2_q;
					bx_q   <= px_q;
					by_q   <= py_q;
				end
			end
			ST_ORIENT: begin
				if (!have_q) begin
					r_hit_q    <= 1'b1;
					r_px_q     <= '0;
					r_py_q     <= '0;
					r_status_q <= st_ok;
				end
			end
			ST_DOTWAIT: begin
				if (mul_stat.done) begin
					if (!comp_q) begin
						acc_q <= mul_prod;
					end else begin
						r_hit_q    <= 1'b1;
						r_px_q     <= flip_c ? neg_sat(bx_q) : bx_q;
						r_py_q     <= flip_c ? neg_sat(by_q) : by_q;
						r_status_q <= st_ok;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					o_hit_q    <= r_hit_q;
					o_px_q     <= r_px_q;
					o_py_q     <= r_py_q;
					o_status_q <= r_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.push_x == '0 && result.push_y == '0))
		else $error("push vector not zero without hit");

	a_empty_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == psmt_pkg::STATUS_EMPTY) |-> !result.hit)
		else $error("hit reported for an empty polygon");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CNTW'(MAX_VERTICES)) && (cnt_b_q <= CNTW'(MAX_VERTICES)))
		else $error("vertex count beyond limit");

	a_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_start |-> !mul_stat.busy) and (div_start |-> !div_stat.busy))
		else $error("arithmetic unit started while busy");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && vert.last_vertex) |=> (state_q == ST_START))
		else $error("last vertex did not start the test");
endmodule

### rtl/core/psmt_mul.sv
// ----------------------------------------------------------------------------
// psmt_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module psmt_mul #(
	parameter int MA = 64,
	parameter int MB = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MA-1:0]        a,
	input  logic [MB-1:0]        b,
	output logic [MA+MB-1:0]     prod,
	output psmt_pkg::unit_stat_t stat
);
	localparam int CW = $clog2(MB + 1);

	logic [MA-1:0] a_q;
	logic [MA-1:0] hi_q;
	logic [MB-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MA:0]   sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MA:1];
			lo_q <= {sum[0], lo_q[MB-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign stat = '{busy: busy_q, done: done_q};
endmodule

### rtl/core/psmt_div.sv
// ----------------------------------------------------------------------------
// psmt_div
// Restoring divider with a 32-bit quotient and an overflow flag, one bit per cycle.
// ----------------------------------------------------------------------------
module psmt_div #(
	parameter int NW = 112,
	parameter int LW = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [NW-1:0]                 num,
	input  logic [LW-1:0]                 den,
	output logic [psmt_pkg::PUSH_W-1:0]   quo,
	output logic                          sat,
	output psmt_pkg::unit_stat_t          stat
);
	localparam int QW = psmt_pkg::PUSH_W;
	localparam int HW = NW - QW;
	localparam int CW = $clog2(QW + 1);

	logic [LW-1:0] den_q;
	logic [LW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] quo_q;
	logic          sat_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [LW:0]   trial;
	logic          ge;
	logic [LW:0]   diff;
	logic          over;

	assign trial = {rem_q, lo_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	// quotient would need more than 32 bits
	assign over  = num[NW-1:QW] >= HW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (over) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(QW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			sat_q <= over;
			rem_q <= num[QW+LW-1:QW];
			lo_q  <= num[QW-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign sat  = sat_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule
